[rtl/core/bhpq_pkg.sv]
// Package for the button hold progress qualifier: sizes, codes and shared types.
package bhpq_pkg;

    // Block sizes
    localparam int LED_COUNT    = 8;
    localparam int BUTTON_SLOTS = 4;

    // Field widths fixed by the interface
    localparam int BTN_W    = 2;
    localparam int LOCK_W   = 3;
    localparam int HOLD_W   = 8;
    localparam int PROG_W   = 4;
    localparam int ACT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    // Slot address width into the state memory
    localparam int SLOT_AW = (BUTTON_SLOTS > 1) ? $clog2(BUTTON_SLOTS) : 1;

    // Lock code meaning no slot holds the lock
    localparam logic [LOCK_W-1:0] LOCK_NONE = LOCK_W'(BUTTON_SLOTS);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_LOCKED  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HOLDOFF = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CHANGED = 3'd2;
    localparam logic [ACT_W-1:0] ACT_GROW    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SHRINK  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DONE    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_IDLE    = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OFF     = 1'd1;

    // Per-slot state word held in memory
    typedef struct packed {
        logic [HOLD_W-1:0] hold_off_count;
        logic              last_level;
        logic [PROG_W-1:0] progress;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Result item, packed lowest field in the lowest bits
    typedef struct packed {
        logic [BTN_W-1:0]  source_button;
        logic              completed;
        logic              power_off_check;
        logic              power_on_request;
        logic [PROG_W-1:0] lit_count;
        logic [ACT_W-1:0]  action;
    } t_result;

    localparam int RES_W = $bits(t_result);

    // Update stage outputs toward the pipeline control
    typedef struct packed {
        logic              wr;
        logic [LOCK_W-1:0] lock;
        t_slot             slot;
        t_result           result;
    } t_upd_out;

endpackage

[rtl/core/button_hold_progress_qualifier.sv]
// Top level of the button hold progress qualifier.
// Takes one button sample per request and returns one result per sample. A sample
// is accepted every cycle in steady flow; its result passes the state memory read
// stage and the output register, and the pipeline stalls only when the result side
// holds off. Per-slot state lives in a small memory with registered read data; a
// sample that follows one for the same slot gets the freshly written state
// forwarded. After reset every slot reads as cleared through per-slot valid bits,
// so no clearing pass is needed. The user must write configuration through the
// plain write port only while the block is idle; the block does not enforce this.
module button_hold_progress_qualifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // sample requests
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // button[1:0], level[2], zero fill
    // result requests
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // action[2:0], lit_count[6:3],
                                          // power_on_request[7], power_off_check[8],
                                          // completed[9], source_button[11:10], zero fill
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [bhpq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bhpq_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    localparam int AW = bhpq_pkg::SLOT_AW;

    // configuration
    logic                          r_cfg_active;
    logic [bhpq_pkg::HOLD_W-1:0]   r_cfg_hold;

    // state memory tracking and forwarding
    logic [bhpq_pkg::BUTTON_SLOTS-1:0] r_valid;
    logic                              r_rd_vld;
    logic                              r_fwd_hit;
    bhpq_pkg::t_slot                   r_fwd_data;
    logic [bhpq_pkg::LOCK_W-1:0]       r_lock;

    // read stage
    logic                          r_s1_valid;
    logic [bhpq_pkg::BTN_W-1:0]    r_s1_btn;
    logic                          r_s1_lvl;

    // output register
    logic                          r_out_valid;
    bhpq_pkg::t_result             r_out;

    logic                          in_fire;
    logic                          s1_adv;
    logic                          s1_wr;
    logic [bhpq_pkg::BTN_W-1:0]    in_btn;
    logic                          in_lvl;
    logic [AW-1:0]                 in_addr;
    logic [AW-1:0]                 s1_addr;
    logic [bhpq_pkg::SLOT_W-1:0]   ram_rdata;
    bhpq_pkg::t_slot               cur_slot;
    bhpq_pkg::t_upd_out            upd;

    assign in_btn  = i_s_axis_tdata[1:0];
    assign in_lvl  = i_s_axis_tdata[2];
    assign in_addr = AW'(in_btn);
    assign s1_addr = AW'(r_s1_btn);

    // handshake
    assign s1_adv          = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || s1_adv;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;
    assign s1_wr           = r_s1_valid && s1_adv && upd.wr;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_active <= 1'b0;
            r_cfg_hold   <= bhpq_pkg::HOLD_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bhpq_pkg::CFG_ACTIVE_LEVEL: r_cfg_active <= i_cfg_wdata[0];
                bhpq_pkg::CFG_HOLD_OFF:     r_cfg_hold   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // per-slot state memory
    bhpq_ram #(
        .WIDTH (bhpq_pkg::SLOT_W),
        .DEPTH (bhpq_pkg::BUTTON_SLOTS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_wr),
        .i_waddr (s1_addr),
        .i_wdata (upd.slot),
        .i_re    (in_fire),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // current slot state: forwarded write, memory, or cleared
    always_comb begin
        priority if (r_fwd_hit) begin
            cur_slot = r_fwd_data;
        end else if (r_rd_vld) begin
            cur_slot = bhpq_pkg::t_slot'(ram_rdata);
        end else begin
            cur_slot = '0;
        end
    end

    bhpq_update u_update (
        .i_cur              (cur_slot),
        .i_button           (r_s1_btn),
        .i_level            (r_s1_lvl),
        .i_lock             (r_lock),
        .i_active_level     (r_cfg_active),
        .i_hold_off_samples (r_cfg_hold),
        .o_upd              (upd)
    );

    // read stage control and forwarding capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
            r_fwd_hit  <= s1_wr && (s1_addr == in_addr);
            r_rd_vld   <= r_valid[in_addr];
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_btn   <= in_btn;
            r_s1_lvl   <= in_lvl;
            r_fwd_data <= upd.slot;
        end
    end

    // valid bits and lock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_lock  <= bhpq_pkg::LOCK_NONE;
        end else if (r_s1_valid && s1_adv) begin
            r_lock <= upd.lock;
            if (upd.wr) begin
                r_valid[s1_addr] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out <= upd.result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(16 - bhpq_pkg::RES_W)'(0), r_out};

endmodule

[rtl/core/bhpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bhpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-edge write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/bhpq_update.sv]
// Read-modify-write logic: next slot state, lock and result for one sample.
module bhpq_update (
    input  bhpq_pkg::t_slot                   i_cur,
    input  logic [bhpq_pkg::BTN_W-1:0]        i_button,
    input  logic                              i_level,
    input  logic [bhpq_pkg::LOCK_W-1:0]       i_lock,
    input  logic                              i_active_level,
    input  logic [bhpq_pkg::HOLD_W-1:0]       i_hold_off_samples,
    output bhpq_pkg::t_upd_out                o_upd
);

    logic in_range;
    logic locked_out;
    logic pressed;

    assign in_range   = int'(i_button) < bhpq_pkg::BUTTON_SLOTS;
    assign locked_out = (i_lock != bhpq_pkg::LOCK_NONE) &&
                        (i_lock != bhpq_pkg::LOCK_W'(i_button));
    assign pressed    = (i_level == i_active_level);

    always_comb begin
        // default: locked-out answer, nothing written
        o_upd                      = '0;
        o_upd.lock                 = i_lock;
        o_upd.slot                 = i_cur;
        o_upd.result.action        = bhpq_pkg::ACT_LOCKED;
        o_upd.result.source_button = i_button;

        if (in_range && !locked_out) begin
            o_upd.wr              = 1'b1;
            o_upd.slot.last_level = i_level;
            priority if (i_cur.hold_off_count != '0) begin
                // hold-off: released samples count down
                if (!pressed) begin
                    o_upd.slot.hold_off_count = i_cur.hold_off_count - 1'b1;
                end
                o_upd.result.action          = bhpq_pkg::ACT_HOLDOFF;
                o_upd.result.lit_count       = i_cur.progress;
                o_upd.result.power_off_check = 1'b1;
            end else if (i_cur.last_level != i_level) begin
                o_upd.result.action    = bhpq_pkg::ACT_CHANGED;
                o_upd.result.lit_count = i_cur.progress;
            end else if (pressed) begin
                if (i_cur.progress < bhpq_pkg::PROG_W'(bhpq_pkg::LED_COUNT)) begin
                    // grow and take the lock
                    o_upd.lock                    = bhpq_pkg::LOCK_W'(i_button);
                    o_upd.slot.progress           = i_cur.progress + 1'b1;
                    o_upd.result.action           = bhpq_pkg::ACT_GROW;
                    o_upd.result.lit_count        = i_cur.progress + 1'b1;
                    o_upd.result.power_on_request = 1'b1;
                end else begin
                    // full bar: complete, re-arm hold-off, free the lock
                    o_upd.lock                = bhpq_pkg::LOCK_NONE;
                    o_upd.slot.hold_off_count = i_hold_off_samples;
                    o_upd.slot.progress       = '0;
                    o_upd.result.action       = bhpq_pkg::ACT_DONE;
                    o_upd.result.completed    = 1'b1;
                end
            end else begin
                if (i_cur.progress != '0) begin
                    o_upd.slot.progress           = i_cur.progress - 1'b1;
                    o_upd.result.action           = bhpq_pkg::ACT_SHRINK;
                    o_upd.result.lit_count        = i_cur.progress - 1'b1;
                    o_upd.result.power_on_request = 1'b1;
                end else begin
                    o_upd.lock                   = bhpq_pkg::LOCK_NONE;
                    o_upd.result.action          = bhpq_pkg::ACT_IDLE;
                    o_upd.result.power_off_check = 1'b1;
                end
            end
        end
    end

endmodule

[rtl/core/bhpq_checker.sv]
// Port-level checker for the button hold progress qualifier, bound to the top level.
module bhpq_port_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] o_m_axis_tdata
);

    logic in_fire;
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("result changed while stalled");

    // a new result comes from a request that passed the read stage and the output register
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(in_fire, 2))
        else $error("result without a matching request");

    // supply request only with grow or shrink
    a_pon_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[7]) |->
            (o_m_axis_tdata[2:0] == bhpq_pkg::ACT_GROW ||
             o_m_axis_tdata[2:0] == bhpq_pkg::ACT_SHRINK))
        else $error("power request on wrong action");

    // completion empties the bar and matches its action
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[9]) |->
            (o_m_axis_tdata[2:0] == bhpq_pkg::ACT_DONE && o_m_axis_tdata[6:3] == 4'd0))
        else $error("bad completion result");

endmodule

bind button_hold_progress_qualifier bhpq_port_checker u_bhpq_checker (.*);

[verif/bhpq_checker.sv]
// Result checker for the button hold progress qualifier: tracks slot state and compares results.
`timescale 1ns / 100ps
module bhpq_checker
    import bhpq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample side, watched only
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [7:0]            i_s_tdata,    // button[1:0], level[2], zero fill
    // result side, watched only
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [15:0]           i_m_tdata,    // action, lit_count, power_on_request,
                                                // power_off_check, completed, source_button
    // register writes
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_pending,
    output int                    o_results
);

    // Shadow copy of the per-slot state and the lock
    logic [HOLD_W-1:0] holdoff_left [BUTTON_SLOTS];
    logic              level_seen   [BUTTON_SLOTS];
    logic [PROG_W-1:0] bar_len      [BUTTON_SLOTS];
    logic [LOCK_W-1:0] lock_owner;

    // Shadow copy of the registers
    logic              press_level;
    logic [HOLD_W-1:0] holdoff_reload;

    t_result           expected_results [$];
    t_result           got;
    t_result           want;

    // One sample through the qualifier; updates the shadow state
    function automatic t_result qualify_sample(input logic [BTN_W-1:0] btn, input logic lvl);
        t_result r;
        logic    pressed;
        r               = '0;
        r.action        = ACT_LOCKED;
        r.source_button = btn;
        // slot past the table, or another slot owns the animation
        if (int'(btn) >= BUTTON_SLOTS) return r;
        if (lock_owner != LOCK_NONE && lock_owner != LOCK_W'(btn)) return r;

        pressed = (lvl == press_level);

        // hold-off: only released samples count it down
        if (holdoff_left[btn] != '0) begin
            if (!pressed) holdoff_left[btn] = holdoff_left[btn] - 1'b1;
            level_seen[btn]   = lvl;
            r.action          = ACT_HOLDOFF;
            r.lit_count       = bar_len[btn];
            r.power_off_check = 1'b1;
            return r;
        end

        // an edge is only recorded
        if (level_seen[btn] != lvl) begin
            level_seen[btn] = lvl;
            r.action        = ACT_CHANGED;
            r.lit_count     = bar_len[btn];
            return r;
        end

        if (pressed) begin
            if (bar_len[btn] < LED_COUNT) begin
                lock_owner         = LOCK_W'(btn);
                bar_len[btn]       = bar_len[btn] + 1'b1;
                r.action           = ACT_GROW;
                r.lit_count        = bar_len[btn];
                r.power_on_request = 1'b1;
            end else begin
                // full bar: hold done, re-arm hold-off
                holdoff_left[btn] = holdoff_reload;
                bar_len[btn]      = '0;
                lock_owner        = LOCK_NONE;
                r.action          = ACT_DONE;
                r.completed       = 1'b1;
            end
        end else begin
            if (bar_len[btn] != '0) begin
                bar_len[btn]       = bar_len[btn] - 1'b1;
                r.action           = ACT_SHRINK;
                r.lit_count        = bar_len[btn];
                r.power_on_request = 1'b1;
            end else begin
                lock_owner        = LOCK_NONE;
                r.action          = ACT_IDLE;
                r.power_off_check = 1'b1;
            end
        end
        return r;
    endfunction

    // Print one line (first few only) and count
    task automatic report_mismatch(input string what);
        o_mismatches++;
        if (o_mismatches <= 40) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input int got_val, input int want_val);
        if (got_val != want_val)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got_val, want_val));
    endtask

    // Everything sampled at the clock edge, same view as the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < BUTTON_SLOTS; s++) begin
                holdoff_left[s] = '0;
                level_seen[s]   = 1'b0;
                bar_len[s]      = '0;
            end
            lock_owner     = LOCK_NONE;
            press_level    = 1'b0;
            holdoff_reload = HOLD_W'(10);
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ACTIVE_LEVEL: press_level    = i_cfg_wdata[0];
                    CFG_HOLD_OFF:     holdoff_reload = i_cfg_wdata[HOLD_W-1:0];
                    default: ;
                endcase
            end

            // result request: compare with the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                o_results++;
                got = t_result'(i_m_tdata[RES_W-1:0]);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %h with nothing expected", i_m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    check_field("action", got.action, want.action);
                    check_field("lit_count", got.lit_count, want.lit_count);
                    check_field("power_on_request", got.power_on_request,
                                want.power_on_request);
                    check_field("power_off_check", got.power_off_check, want.power_off_check);
                    check_field("completed", got.completed, want.completed);
                    check_field("source_button", got.source_button, want.source_button);
                end
            end

            // sample request: predict its result
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(qualify_sample(i_s_tdata[BTN_W-1:0],
                                                          i_s_tdata[BTN_W]));
        end
        o_pending = expected_results.size();
    end

endmodule

[verif/tb_top.sv]
// Testbench top for the button hold progress qualifier: stimulus, idling, watchdog and verdict.
`timescale 1ns / 100ps
module tb_top;
    import bhpq_pkg::*;

    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 180;
    localparam int RX_HOLD     = 60;
    localparam int STALL_LIMIT = 2000;
    // per phase: pressed level (bit p) and hold-off reload (byte p)
    localparam logic [PHASES-1:0]   PH_ACTIVE = 6'b010101;
    localparam logic [PHASES*8-1:0] PH_HOLD   = {8'd255, 8'd2, 8'd0, 8'd1, 8'd3, 8'd0};

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches;
    int pending;
    int results;

    bit   calm        = 1'b0;
    bit   rx_hold_req = 1'b0;
    logic act_lvl     = 1'b0;
    int   n_sent      = 0;
    int   stall_cycles = 0;

    button_hold_progress_qualifier dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    bhpq_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: random holds, or one long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req <= 1'b0;
                m_tready    <= 1'b0;
                repeat (RX_HOLD) @(posedge clk);
            end else begin
                m_tready <= calm || ($urandom_range(99) >= 14);
            end
        end
    end

    // Watchdog: too long without any request moving
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Offer one sample; entered and left at a rising edge. Ready is looked at
    // on the falling edge, where everything driven at the rising edge is settled.
    task automatic send_sample(input logic [BTN_W-1:0] btn, input logic lvl, input bit counted);
        if (!calm && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, lvl, btn};
        @(negedge clk);
        while (!s_tready) @(negedge clk);
        @(posedge clk);
        if (counted) n_sent++;
    endtask

    // Stop offering and wait until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // A press of press_len samples then a release of release_len, with stray
    // samples from random slots mixed in
    task automatic play_hold(input logic [BTN_W-1:0] slot, input int press_len,
                             input int release_len);
        for (int k = 0; k < press_len + release_len; k++) begin
            if ($urandom_range(99) < 12)
                send_sample($urandom_range(BUTTON_SLOTS-1), $urandom_range(1), 1'b1);
            send_sample(slot, (k < press_len) ? act_lvl : ~act_lvl, 1'b1);
        end
    endtask

    initial begin
        int  target;
        int  rel_len;
        bit  hold_done;
        hold_done = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings (pressed = 0, hold-off 10)
        // full hold on slot 0: eight grows then completion
        repeat (9) send_sample(2'd0, 1'b0, 1'b1);
        // slot 1 takes the lock, slot 2 is locked out
        send_sample(2'd1, 1'b0, 1'b1);
        send_sample(2'd2, 1'b1, 1'b1);
        // slot 1: edge, shrink to empty, idle frees the lock
        repeat (3) send_sample(2'd1, 1'b1, 1'b1);
        // slot 0 in hold-off: pressed keeps the count, released counts down
        send_sample(2'd0, 1'b0, 1'b1);
        send_sample(2'd0, 1'b1, 1'b1);
        // slot 3: edge then idle
        repeat (2) send_sample(2'd3, 1'b1, 1'b1);

        // Random phases, one register setting each
        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            write_reg(CFG_ACTIVE_LEVEL, CFG_DATA_W'(PH_ACTIVE[p]));
            write_reg(CFG_HOLD_OFF, PH_HOLD[p*8 +: 8]);
            act_lvl = PH_ACTIVE[p];
            calm   <= (p == 0);
            target  = n_sent + PHASE_ITEMS;
            while (n_sent < target) begin
                if (p == 2 && !hold_done && n_sent > target - PHASE_ITEMS / 2) begin
                    rx_hold_req <= 1'b1;
                    hold_done    = 1'b1;
                end
                // most releases are long enough to empty the bar and free the lock
                rel_len = ($urandom_range(99) < 80) ? 10 : $urandom_range(0, 3);
                play_hold($urandom_range(BUTTON_SLOTS-1), $urandom_range(0, 12), rel_len);
            end
        end

        drain_results();
        $display("Covered %0d samples and %0d checked results over %0d register settings",
                 n_sent, results, PHASES + 1);
        $display("(both pressed levels, hold-off 0 to 255, long result hold); mismatches: %0d",
                 mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
